// ===== rtl/core/acpd_pkg.sv =====
`default_nettype none

package acpd_pkg;

   // Field and register widths
   localparam int PERIOD_W    = 10;
   localparam int MIN_PULSE_W = 8;
   localparam int THRESH_W    = 7;
   localparam int WIDTH_W     = 8;   // pulse width only ever compared to an 8-bit minimum
   localparam int COUNT_W     = 8;
   localparam int BUCKET_W    = 8;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Register map, word index = paddr[3:2]
   localparam logic [1:0] REG_PERIOD_MS    = 2'd0;
   localparam logic [1:0] REG_MIN_PULSE_MS = 2'd1;
   localparam logic [1:0] REG_THRESHOLD    = 2'd2;

   // Reset values of the registers
   localparam logic [PERIOD_W-1:0]    PERIOD_RESET    = 10'd20;
   localparam logic [MIN_PULSE_W-1:0] MIN_PULSE_RESET = 8'd5;
   localparam logic [THRESH_W-1:0]    THRESH_RESET    = 7'd3;

   // Saturation limits
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX = {WIDTH_W{1'b1}};
   localparam logic [PERIOD_W-1:0] TIMER_MAX = {PERIOD_W{1'b1}};

   typedef struct packed {
      logic [PERIOD_W-1:0]    period_ms;
      logic [MIN_PULSE_W-1:0] min_pulse_ms;
      logic [THRESH_W-1:0]    threshold;
   } cfg_type;

   typedef struct packed {
      logic switch_closed;
      logic state_published;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/ac_presence_leaky_bucket_detector.sv =====
`default_nettype none

// AC presence detector. Each input word is one millisecond tick carrying the
// sampled pin level; each tick yields exactly one result word with the current
// switch state and a flag for a state published on that tick. High pulses of
// at least min_pulse_ms ticks are counted; every period_ms ticks a leaky
// bucket fills (count moved) or drains (count idle), reporting closed above
// threshold and open at empty. Throughput is one word per clock while the
// result stream is ready; a word passes the input and result registers, with
// the whole state update done in the single stage between them. Registers
// sit at byte addresses 0 (period_ms), 4 (min_pulse_ms) and 8 (threshold).
module ac_presence_leaky_bucket_detector (
   input  wire                              clock,
   input  wire                              reset,
   // input stream
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [7:0]                       req_tdata,   // [0] pin_level
   // result stream
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [0] switch_closed, [1] state_published
   // configuration port
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [acpd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [acpd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [acpd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import acpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] csr_index;
   logic       csr_write;

   logic       in_valid_ff, in_valid_in;
   logic       in_pin_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   logic       advance;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PERIOD_MS:    cfg_in.period_ms    = csr_pwdata[PERIOD_W-1:0];
            REG_MIN_PULSE_MS: cfg_in.min_pulse_ms = csr_pwdata[MIN_PULSE_W-1:0];
            REG_THRESHOLD:    cfg_in.threshold    = csr_pwdata[THRESH_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PERIOD_MS:    csr_prdata = CSR_DATA_W'(cfg_ff.period_ms);
         REG_MIN_PULSE_MS: csr_prdata = CSR_DATA_W'(cfg_ff.min_pulse_ms);
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(cfg_ff.threshold);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ms    <= PERIOD_RESET;
         cfg_ff.min_pulse_ms <= MIN_PULSE_RESET;
         cfg_ff.threshold    <= THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Pipeline flow: input register -> state update -> result register
   assign advance      = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready   = ~in_valid_ff | advance;
   assign in_valid_in  = req_tvalid | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         in_pin_ff <= req_tdata[0];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   acpd_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step_en   (advance),
      .pin_level (in_pin_ff),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ff.state_published, out_ff.switch_closed};

endmodule

`default_nettype wire

// ===== rtl/core/acpd_tracker.sv =====
`default_nettype none

module acpd_tracker (
   input  wire                  clock,
   input  wire                  reset,
   input  acpd_pkg::cfg_type    cfg,
   input  wire                  step_en,
   input  wire                  pin_level,
   output acpd_pkg::result_type result
);
   import acpd_pkg::*;

   logic                  prev_pin_ff,   prev_pin_in;
   logic                  pulse_open_ff, pulse_open_in;
   logic [WIDTH_W-1:0]    width_ff,      width_in;
   logic [COUNT_W-1:0]    count_ff,      count_in;
   logic [COUNT_W-1:0]    last_count_ff, last_count_in;
   logic [BUCKET_W-1:0]   bucket_ff,     bucket_in;
   logic [PERIOD_W-1:0]   timer_ff,      timer_in;
   logic                  closed_ff,     closed_in;

   logic                  rising;
   logic                  falling;
   logic [WIDTH_W-1:0]    width_inc;
   logic [PERIOD_W:0]     timer_inc;
   logic                  check;
   logic [BUCKET_W-1:0]   bucket_cap;
   logic [BUCKET_W-1:0]   bucket_dec;
   logic [BUCKET_W-1:0]   bucket_up;
   logic                  published;

   // Pulse edge detection, width timing and qualification
   always_comb begin
      rising        = pin_level & ~prev_pin_ff;
      falling       = ~pin_level & prev_pin_ff;
      width_inc     = (width_ff == WIDTH_MAX) ? WIDTH_MAX : width_ff + 1'b1;
      pulse_open_in = pulse_open_ff;
      width_in      = width_ff;
      count_in      = count_ff;
      if (rising) begin
         pulse_open_in = 1'b1;
         width_in      = '0;
      end else if (pulse_open_ff) begin
         width_in = width_inc;
         if (falling) begin
            if (width_inc >= cfg.min_pulse_ms) begin
               count_in = count_ff + 1'b1;
            end
            pulse_open_in = 1'b0;
            width_in      = '0;
         end
      end
      prev_pin_in = pin_level;
   end

   // Period check and leaky bucket; uses this tick's updated pulse count
   always_comb begin
      timer_inc     = {1'b0, timer_ff} + 1'b1;
      check         = timer_inc >= {1'b0, cfg.period_ms};
      bucket_cap    = {cfg.threshold, 1'b0};
      bucket_dec    = bucket_ff - 1'b1;
      bucket_up     = bucket_ff + 1'b1;
      timer_in      = timer_inc[PERIOD_W-1:0];
      bucket_in     = bucket_ff;
      closed_in     = closed_ff;
      last_count_in = last_count_ff;
      published     = 1'b0;
      if (check) begin
         if (count_in == last_count_ff) begin
            if (bucket_ff != '0) begin
               bucket_in = bucket_dec;
               if (bucket_dec == '0) begin
                  closed_in = 1'b0;
                  published = 1'b1;
               end
            end
         end else begin
            if (bucket_ff < bucket_cap) begin
               bucket_in = bucket_up;
               if (bucket_up > {1'b0, cfg.threshold}) begin
                  closed_in = 1'b1;
                  published = 1'b1;
               end
            end
         end
         last_count_in = count_in;
         timer_in      = '0;
      end
   end

   assign result.switch_closed   = closed_in;
   assign result.state_published = published;

   // State update, one tick per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pin_ff   <= 1'b0;
         pulse_open_ff <= 1'b0;
         width_ff      <= '0;
         count_ff      <= '0;
         last_count_ff <= '0;
         bucket_ff     <= '0;
         timer_ff      <= '0;
         closed_ff     <= 1'b0;
      end else if (step_en) begin
         prev_pin_ff   <= prev_pin_in;
         pulse_open_ff <= pulse_open_in;
         width_ff      <= width_in;
         count_ff      <= count_in;
         last_count_ff <= last_count_in;
         bucket_ff     <= bucket_in;
         timer_ff      <= timer_in;
         closed_ff     <= closed_in;
      end
   end

`ifndef SYNTH
   // Reported state only moves on a tick
   a_closed_moves_on_tick: assert property (@(posedge clock) disable iff (reset)
      (closed_ff != $past(closed_ff)) |-> $past(step_en))
      else $error("closed state changed without a tick");

   // An idle pulse tracker holds a cleared width
   a_width_clear_when_idle: assert property (@(posedge clock) disable iff (reset)
      !pulse_open_ff |-> (width_ff == '0))
      else $error("pulse width nonzero with no pulse open");

   // Stored timer always stays below the largest period
   a_timer_below_max: assert property (@(posedge clock) disable iff (reset)
      timer_ff != TIMER_MAX)
      else $error("period timer reached its limit");

   // Bucket only changes on a check tick
   a_bucket_on_check: assert property (@(posedge clock) disable iff (reset)
      (step_en && !check) |=> (bucket_ff == $past(bucket_ff)))
      else $error("bucket changed outside a check");
`endif

endmodule

`default_nettype wire
